[sv/mnes_pkg.sv]
// Shared types, constants and codes of the MIDI note echo scheduler.
package mnes_pkg;

  // Default table size and the per-tick result limit.
  localparam int unsigned SlotsDef   = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned NumW       = $clog2(MaxResults + 1);

  // Fixed key-on duration and the register reset values of the echo behavior.
  localparam logic [14:0]        KeyonDur   = 15'd100;
  localparam logic [14:0]        DelayRst   = 15'd500;
  localparam logic signed [7:0]  VelStepRst = -8'sd10;
  localparam logic signed [7:0]  PitStepRst = 8'sd0;
  localparam logic [4:0]         ChanSelRst = 5'd0;

  // Input command codes.
  localparam logic CmdEvent = 1'b0;
  localparam logic CmdTick  = 1'b1;

  // Event kind codes.
  localparam logic KindNote  = 1'b0;
  localparam logic KindKeyOn = 1'b1;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    RegDelay   = 2'd0,
    RegVelStep = 2'd1,
    RegPitStep = 2'd2,
    RegChanSel = 2'd3
  } reg_idx_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVENT,
    ST_SCAN
  } state_e;

  // One input request.
  typedef struct packed {
    logic        cmd;
    logic        event_kind;
    logic [7:0]  port;
    logic [3:0]  channel;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [14:0] duration;
  } in_t;

  // One result request.
  typedef struct packed {
    logic [7:0]  echo_port;
    logic [3:0]  echo_channel;
    logic [6:0]  echo_pitch;
    logic [6:0]  echo_velocity;
    logic [14:0] echo_duration;
    logic        last;
  } out_t;

  // One echo table entry; its valid bit lives in flip-flops.
  typedef struct packed {
    logic [7:0]  port;
    logic [3:0]  channel;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [14:0] duration;
    logic [14:0] count;
  } entry_t;

  // Configuration register contents.
  typedef struct packed {
    logic [14:0]        delay_ms;
    logic signed [7:0]  velocity_step;
    logic signed [7:0]  pitch_step;
    logic [4:0]         channel_select;
  } cfg_t;

endpackage

[sv/mnes_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mnes_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/mnes_regs.sv]
// APB configuration registers of the MIDI note echo scheduler.
module mnes_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mnes_pkg::cfg_t     cfg_o
);
  import mnes_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_ms       <= DelayRst;
      cfg_q.velocity_step  <= VelStepRst;
      cfg_q.pitch_step     <= PitStepRst;
      cfg_q.channel_select <= ChanSelRst;
    end else if (wr_en) begin
      case (idx)
        RegDelay:   cfg_q.delay_ms       <= pwdata[14:0];
        RegVelStep: cfg_q.velocity_step  <= pwdata[7:0];
        RegPitStep: cfg_q.pitch_step     <= pwdata[7:0];
        RegChanSel: cfg_q.channel_select <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register reads, zero extended.
  always_comb begin
    case (idx)
      RegDelay:   prdata = {17'd0, cfg_q.delay_ms};
      RegVelStep: prdata = {24'd0, cfg_q.velocity_step};
      RegPitStep: prdata = {24'd0, cfg_q.pitch_step};
      RegChanSel: prdata = {27'd0, cfg_q.channel_select};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

[sv/midi_note_echo_scheduler.sv]
// Top level of the MIDI note echo scheduler: sequencer, echo table and result buffering.
// A tick request scans the table one slot per cycle unless out_stall_i holds the result
// path; the single table read port sets that rate, and the next request is taken only
// once the scan is done. An event request searches for the lowest free slot, one slot
// per cycle, and one that the filter drops does not leave the idle state.
// Results of a tick are delivered through a one-deep hold buffer and an output register.
// Reset clears all slot valid bits at once and loads the register reset values; no
// clearing pass runs.
module midi_note_echo_scheduler #(
  parameter int unsigned SLOTS = mnes_pkg::SlotsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  mnes_pkg::in_t  in_data_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output mnes_pkg::out_t out_data_o,
  input  logic           out_stall_i,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import mnes_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  cfg_t            cfg;
  state_e          state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            e_vld_q, e_vld_d;
  logic [IdxW-1:0] e_idx_q, e_idx_d;
  logic [NumW-1:0] n_q, n_d;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic            pend_vld_q, pend_vld_d;
  out_t            pend_q, pend_d;
  logic            out_vld_q;
  out_t            out_q;
  entry_t          ev_q, ev_d;

  logic            in_acc;
  logic            ev_ok;
  logic            out_free;
  logic            out_load;
  out_t            out_load_data;
  logic            evt_done;
  logic            scan_done;
  logic            scan_stall;
  logic            emit_req;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata;
  logic            ram_re;
  entry_t          rd_ent;

  logic            slot_v;
  logic            due;
  logic            room;
  logic signed [8:0] vsum;
  logic signed [8:0] psum;
  logic            ok;
  entry_t          upd_ent;
  entry_t          dec_ent;
  out_t            new_res;
  logic [IdxW-1:0] cur_idx;

  // Configuration registers.
  mnes_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Echo table payload storage.
  mnes_ram #(
    .Width ($bits(entry_t)),
    .Depth (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cur_idx),
    .rdata_o (rd_ent)
  );

  // Handshake on both channels.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign cur_idx     = idx_q[IdxW-1:0];

  // Event filter: channel selection and silent key-on.
  assign ev_ok = (in_data_i.cmd == CmdEvent) &&
                 ((cfg.channel_select == 5'd0) ||
                  (cfg.channel_select == ({1'b0, in_data_i.channel} + 5'd1))) &&
                 !((in_data_i.event_kind == KindKeyOn) && (in_data_i.velocity == 7'd0));

  // Evaluation of the slot whose data the table just returned.
  assign slot_v = valid_q[e_idx_q];
  assign due    = (rd_ent.count <= 15'd1);
  assign room   = (n_q < NumW'(MaxResults));
  assign vsum   = $signed({2'b00, rd_ent.velocity}) +
                  $signed({cfg.velocity_step[7], cfg.velocity_step});
  assign psum   = $signed({2'b00, rd_ent.pitch}) +
                  $signed({cfg.pitch_step[7], cfg.pitch_step});
  assign ok     = (vsum[8:7] == 2'b00) && (vsum[6:0] != 7'd0) && (psum[8:7] == 2'b00);

  always_comb begin
    upd_ent          = rd_ent;
    upd_ent.velocity = vsum[6:0];
    upd_ent.pitch    = psum[6:0];
    upd_ent.count    = cfg.delay_ms;
    dec_ent          = rd_ent;
    dec_ent.count    = rd_ent.count - 15'd1;
    new_res.echo_port     = rd_ent.port;
    new_res.echo_channel  = rd_ent.channel;
    new_res.echo_pitch    = psum[6:0];
    new_res.echo_velocity = vsum[6:0];
    new_res.echo_duration = rd_ent.duration;
    new_res.last          = 1'b0;
  end

  assign emit_req   = (state_q == ST_SCAN) && e_vld_q && slot_v && due && room && ok;
  assign scan_stall = emit_req && pend_vld_q && !out_free;

  // Datapath control of the sequencer.
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = e_idx_q;
    ram_wdata     = rd_ent;
    ram_re        = 1'b0;
    idx_d         = idx_q;
    e_vld_d       = e_vld_q;
    e_idx_d       = e_idx_q;
    n_d           = n_q;
    valid_d       = valid_q;
    pend_vld_d    = pend_vld_q;
    pend_d        = pend_q;
    out_load      = 1'b0;
    out_load_data = pend_q;
    ev_d          = ev_q;
    evt_done      = 1'b0;
    scan_done     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d       = '0;
          n_d         = '0;
          e_vld_d     = 1'b0;
          ev_d.port     = in_data_i.port;
          ev_d.channel  = in_data_i.channel;
          ev_d.pitch    = in_data_i.pitch;
          ev_d.velocity = in_data_i.velocity;
          ev_d.duration = (in_data_i.event_kind == KindKeyOn) ? KeyonDur
                                                               : in_data_i.duration;
          ev_d.count    = cfg.delay_ms;
        end
      end
      ST_EVENT: begin
        // Search for the lowest free slot, one slot per cycle.
        if (!valid_q[cur_idx]) begin
          ram_we           = 1'b1;
          ram_waddr        = cur_idx;
          ram_wdata        = ev_q;
          valid_d[cur_idx] = 1'b1;
          evt_done         = 1'b1;
        end else if (cur_idx == IdxW'(SLOTS - 1)) begin
          evt_done = 1'b1;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      ST_SCAN: begin
        // Act on the evaluated slot unless the result path is full.
        if (e_vld_q && slot_v && !scan_stall) begin
          if (!due) begin
            ram_we    = 1'b1;
            ram_wdata = dec_ent;
          end else if (room) begin
            if (ok) begin
              ram_we    = 1'b1;
              ram_wdata = upd_ent;
              if (pend_vld_q) begin
                out_load      = 1'b1;
                out_load_data = pend_q;
              end
              pend_d     = new_res;
              pend_vld_d = 1'b1;
              n_d        = n_q + NumW'(1);
            end else begin
              valid_d[e_idx_q] = 1'b0;
            end
          end
        end
        // Issue the next table read.
        if (!scan_stall) begin
          if (idx_q < CntW'(SLOTS)) begin
            ram_re  = 1'b1;
            e_vld_d = 1'b1;
            e_idx_d = cur_idx;
            idx_d   = idx_q + CntW'(1);
          end else begin
            e_vld_d = 1'b0;
          end
        end
        // After the last slot, release the held result marked as last.
        if ((idx_q == CntW'(SLOTS)) && !e_vld_q) begin
          if (pend_vld_q) begin
            if (out_free) begin
              out_load           = 1'b1;
              out_load_data      = pend_q;
              out_load_data.last = 1'b1;
              pend_vld_d         = 1'b0;
              scan_done          = 1'b1;
            end
          end else begin
            scan_done = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.cmd == CmdTick)) begin
          state_d = ST_SCAN;
        end else if (in_acc && ev_ok) begin
          state_d = ST_EVENT;
        end
      end
      ST_EVENT: begin
        if (evt_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      e_vld_q    <= 1'b0;
      n_q        <= '0;
      valid_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      e_vld_q    <= e_vld_d;
      n_q        <= n_d;
      valid_q    <= valid_d;
      pend_vld_q <= pend_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    e_idx_q <= e_idx_d;
    pend_q  <= pend_d;
    ev_q    <= ev_d;
    if (out_load) begin
      out_q <= out_load_data;
    end
  end

  // A held result never outlives its tick.
  a_pend_empty_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld_q)
    else $error("held result left over after the table scan");

  // A stalled scan keeps the slot under evaluation.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_stall |=> (e_vld_q && (e_idx_q == $past(e_idx_q)) && (state_q == ST_SCAN)))
    else $error("slot under evaluation lost during a stall");

  // The per-tick result count stays within its limit.
  a_count_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NumW'(MaxResults))
    else $error("per-tick result count exceeded its limit");

  // A result is only loaded into a free output register.
  a_out_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten while stalled");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the MIDI note echo scheduler, with a table model and random traffic.
module tb_top;
  import mnes_pkg::*;

  localparam int unsigned Slots         = SlotsDef;
  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned ResetCycles   = 10;
  localparam int unsigned DrainCycles   = 2 * Slots + 8;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned TimeoutCycles = 200000;

  // Clock, reset and block ports.
  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  in_t         in_data   = '0;
  logic        in_stall;
  logic        out_valid;
  out_t        out_data;
  logic        out_stall = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Table model, its configuration copy and the echoes it predicts.
  logic [Slots-1:0] slot_used;
  entry_t           slot_entry [Slots];
  cfg_t             echo_cfg;
  out_t             pending_echoes [$];
  in_t              note_reqs_q [$];

  // Handshake and pacing bookkeeping.
  logic        req_taken   = 1'b0;
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_asks   = 0;
  int unsigned hold_seen   = 0;
  int unsigned err_cnt     = 0;

  midi_note_echo_scheduler #(
    .SLOTS(Slots)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_data_i  (in_data),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_data_o (out_data),
    .out_stall_i(out_stall),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // An accepted event takes the lowest free slot unless it is filtered or dropped.
  function automatic void schedule_event(in_t req);
    logic [14:0] dur;
    if (echo_cfg.channel_select != 5'd0 &&
        int'(echo_cfg.channel_select) != int'(req.channel) + 1) return;
    dur = req.duration;
    if (req.event_kind == KindKeyOn) begin
      if (req.velocity == 7'd0) return;
      dur = KeyonDur;
    end
    for (int i = 0; i < Slots; i++) begin
      if (!slot_used[i]) begin
        slot_used[i]  = 1'b1;
        slot_entry[i] = '{port: req.port, channel: req.channel, pitch: req.pitch,
                          velocity: req.velocity, duration: dur, count: echo_cfg.delay_ms};
        return;
      end
    end
  endfunction

  // A tick counts down every slot and fires the due ones in index order.
  function automatic void scan_tick();
    out_t burst [MaxResults];
    int   n;
    int   v;
    int   p;
    n = 0;
    for (int i = 0; i < Slots; i++) begin
      if (!slot_used[i]) continue;
      if (slot_entry[i].count > 15'd1) begin
        slot_entry[i].count = slot_entry[i].count - 15'd1;
        continue;
      end
      // Slots past the result limit stay due for the next tick.
      if (n >= MaxResults) continue;
      v = int'(slot_entry[i].velocity) + int'($signed(echo_cfg.velocity_step));
      p = int'(slot_entry[i].pitch) + int'($signed(echo_cfg.pitch_step));
      if (v > 0 && v < 128 && p >= 0 && p < 128) begin
        slot_entry[i].velocity = 7'(v);
        slot_entry[i].pitch    = 7'(p);
        slot_entry[i].count    = echo_cfg.delay_ms;
        burst[n] = '{echo_port: slot_entry[i].port, echo_channel: slot_entry[i].channel,
                     echo_pitch: 7'(p), echo_velocity: 7'(v),
                     echo_duration: slot_entry[i].duration, last: 1'b0};
        n++;
      end else begin
        slot_used[i]  = 1'b0;
        slot_entry[i] = '0;
      end
    end
    if (n > 0) burst[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) pending_echoes.push_back(burst[k]);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Check each delivered echo request, then feed each accepted input request to the model.
  always @(posedge clk_i) begin : monitor
    out_t want;
    req_taken <= rst_ni && in_valid && !in_stall;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (pending_echoes.size() == 0) begin
          $error("echo request with none expected: port %0d pitch %0d velocity %0d",
                 out_data.echo_port, out_data.echo_pitch, out_data.echo_velocity);
          err_cnt++;
        end else begin
          want = pending_echoes.pop_front();
          check_field("echo_port", want.echo_port, out_data.echo_port);
          check_field("echo_channel", want.echo_channel, out_data.echo_channel);
          check_field("echo_pitch", want.echo_pitch, out_data.echo_pitch);
          check_field("echo_velocity", want.echo_velocity, out_data.echo_velocity);
          check_field("echo_duration", want.echo_duration, out_data.echo_duration);
          check_field("last", want.last, out_data.last);
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.cmd == CmdTick) scan_tick();
        else schedule_event(in_data);
      end
    end
  end

  // The sender offers queued requests in bursts separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // Hold the stalled request unchanged.
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (note_reqs_q.size() != 0) begin
      in_valid <= 1'b1;
      in_data  <= note_reqs_q.pop_front();
      if (burst_left <= 1) begin
        burst_left <= ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // The receiver stalls on its own pattern, with free stretches and a long hold on demand.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= LongHold;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) < 2) begin
      out_stall  <= 1'b0;
      stall_left <= 40;
    end else begin
      out_stall  <= !out_stall;
      stall_left <= out_stall ? $urandom_range(0, 8) : $urandom_range(0, 4);
    end
  end

  // Write one register through a setup phase and an access phase.
  task automatic reg_write(reg_idx_e idx, int value);
    logic [31:0] bits;
    case (idx)
      RegDelay:   bits = 32'(value) & 32'h7FFF;
      RegVelStep: bits = 32'(value) & 32'hFF;
      RegPitStep: bits = 32'(value) & 32'hFF;
      default:    bits = 32'(value) & 32'h1F;
    endcase
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = bits;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegDelay:   echo_cfg.delay_ms       = bits[14:0];
      RegVelStep: echo_cfg.velocity_step  = bits[7:0];
      RegPitStep: echo_cfg.pitch_step     = bits[7:0];
      default:    echo_cfg.channel_select = bits[4:0];
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_echo(int delay, int vel_step, int pit_step, int chan_sel);
    reg_write(RegDelay, delay);
    reg_write(RegVelStep, vel_step);
    reg_write(RegPitStep, pit_step);
    reg_write(RegChanSel, chan_sel);
  endtask

  // Wait until every request is taken and every echo delivered, then let a scan finish.
  task automatic settle();
    while (note_reqs_q.size() != 0 || in_valid || pending_echoes.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic in_t event_req(logic kind, logic [7:0] port, logic [3:0] chan,
                                    logic [6:0] pitch, logic [6:0] vel, logic [14:0] dur);
    return '{cmd: CmdEvent, event_kind: kind, port: port, channel: chan,
             pitch: pitch, velocity: vel, duration: dur};
  endfunction

  // Mostly well-formed events aimed at the selected channel, mixed with ticks.
  function automatic in_t random_request(int tick_pct, int chan_sel);
    in_t r;
    r.cmd        = ($urandom_range(0, 99) < tick_pct) ? CmdTick : CmdEvent;
    r.event_kind = ($urandom_range(0, 3) == 0) ? KindKeyOn : KindNote;
    r.port       = 8'($urandom_range(0, 255));
    if (chan_sel >= 1 && chan_sel <= 16 && $urandom_range(0, 9) < 6)
      r.channel = 4'(chan_sel - 1);
    else
      r.channel = 4'($urandom_range(0, 15));
    r.pitch      = 7'($urandom_range(0, 127));
    r.velocity   = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
    r.duration   = 15'($urandom_range(0, 32767));
    return r;
  endfunction

  task automatic run_phase(int delay, int vel_step, int pit_step, int chan_sel,
                           int count, int tick_pct, bit squeeze);
    set_echo(delay, vel_step, pit_step, chan_sel);
    if (squeeze) hold_asks++;
    for (int k = 0; k < count; k++) note_reqs_q.push_back(random_request(tick_pct, chan_sel));
    settle();
  endtask

  // Main sequence: reset, directed cases, then random phases over several settings.
  initial begin
    echo_cfg  = '{delay_ms: DelayRst, velocity_step: VelStepRst,
                  pitch_step: PitStepRst, channel_select: ChanSelRst};
    slot_used = '0;
    for (int i = 0; i < Slots; i++) slot_entry[i] = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    // Field extremes, key-on with and without velocity, and a silent note.
    set_echo(1, -10, 0, 0);
    note_reqs_q.push_back(event_req(KindNote, 8'd0, 4'd0, 7'd0, 7'd127, 15'd0));
    note_reqs_q.push_back(event_req(KindNote, 8'd255, 4'd15, 7'd127, 7'd1, 15'd32767));
    note_reqs_q.push_back(event_req(KindKeyOn, 8'hAA, 4'd5, 7'd60, 7'd0, 15'd777));
    note_reqs_q.push_back(event_req(KindKeyOn, 8'h55, 4'd10, 7'd64, 7'd64, 15'd12345));
    note_reqs_q.push_back(event_req(KindNote, 8'd7, 4'd3, 7'd30, 7'd0, 15'd5));
    note_reqs_q.push_back(random_request(100, 0));
    note_reqs_q.push_back(random_request(100, 0));
    settle();

    // Overfill the table, then fire every slot with extreme steps and zero delay.
    set_echo(0, 127, -127, 0);
    for (int k = 0; k < 16; k++)
      note_reqs_q.push_back(event_req(KindNote, 8'(k * 17), 4'(k), 7'd127, 7'd0,
                                      15'(k * 2000)));
    note_reqs_q.push_back(random_request(100, 0));
    note_reqs_q.push_back(random_request(100, 0));
    settle();

    run_phase(2, -10, 3, 0, 30, 40, 1'b0);
    // Echoes repeat forever here, so the table fills while the receiver holds off.
    run_phase(1, 0, 0, 0, 35, 50, 1'b1);
    // Every due slot is freed, and only channel 15 is accepted.
    run_phase(3, -127, 127, 16, 25, 40, 1'b0);
    run_phase(0, 5, -1, 1, 30, 45, 1'b0);
    // No channel matches.
    run_phase(4, 127, -127, 31, 15, 40, 1'b0);
    run_phase(32767, -1, 1, 0, 15, 30, 1'b0);

    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Guard against a hang.
  initial begin
    repeat (TimeoutCycles) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
sv/mnes_pkg.sv
sv/mnes_ram.sv
sv/mnes_regs.sv
sv/midi_note_echo_scheduler.sv
dv/tb_top.sv
